[rtl/hrr_pkg.sv]
package hrr_pkg;

   localparam int MAX_BATCH_DEF = 65536;
   localparam int TALLY_W       = 17;
   localparam int TALLY_LIMIT   = 131071;
   localparam int QUEUE_DEPTH   = 2;
   localparam int ADDR_W        = 6;

   localparam logic [2:0] REG_ROT0  = 3'd0;
   localparam logic [2:0] REG_ROT1  = 3'd1;
   localparam logic [2:0] REG_ROT2  = 3'd2;
   localparam logic [2:0] REG_TX    = 3'd3;
   localparam logic [2:0] REG_TY    = 3'd4;
   localparam logic [2:0] REG_TZ    = 3'd5;
   localparam logic [2:0] REG_PP    = 3'd6;
   localparam logic [2:0] REG_FOCAL = 3'd7;

   typedef struct packed {
      logic [2:0][47:0] rot;
      logic [2:0][31:0] trans;
      logic [23:0]      cx;
      logic [23:0]      cy;
      logic [23:0]      f;
      logic [15:0]      k;
   } hrr_cfg_type;

   typedef struct packed {
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
      logic [31:0] ou1;
      logic [31:0] ov1;
      logic [31:0] ou2;
      logic [31:0] ov2;
      logic [31:0] c2x;
      logic [31:0] c2y;
      logic [31:0] c2z;
      logic        ok;
      logic        last;
   } hrr_item_type;

   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [31:0] den;
   } hrr_div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quo;
   } hrr_div_resp_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MAC,
      F_PUSH
   } hrr_front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_MUL,
      B_DIV,
      B_RES,
      B_SQ,
      B_ACC,
      B_MEAN,
      B_MWAIT,
      B_OUT
   } hrr_back_state_type;

endpackage

[rtl/hrr_front.sv]
module hrr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  hrr_pkg::hrr_cfg_type cfg,
   input  logic                 push,
   output logic                 full,
   input  logic [31:0]          req_point_x,
   input  logic [31:0]          req_point_y,
   input  logic [31:0]          req_point_z,
   input  logic                 req_point_ok,
   input  logic [31:0]          req_obs_u1,
   input  logic [31:0]          req_obs_v1,
   input  logic [31:0]          req_obs_u2,
   input  logic [31:0]          req_obs_v2,
   input  logic                 req_batch_end,
   output logic                 q_push,
   output hrr_pkg::hrr_item_type q_item,
   input  logic                 q_full
);

   hrr_pkg::hrr_front_state_type state_ff, state_in;
   hrr_pkg::hrr_item_type        item_ff;
   logic [1:0]                   row_ff, col_ff;
   logic signed [49:0]           acc_ff;

   logic signed [15:0] coef;
   logic signed [31:0] psel;
   logic signed [47:0] prod;
   logic signed [49:0] sum, rnd;
   logic signed [35:0] shd;
   logic signed [36:0] tot;
   logic [31:0]        row_res;
   logic               accept;

   assign full   = (state_ff != hrr_pkg::F_IDLE);
   assign accept = push && !full;

   always_comb begin
      case (col_ff)
         2'd0:    coef = $signed(cfg.rot[row_ff][15:0]);
         2'd1:    coef = $signed(cfg.rot[row_ff][31:16]);
         default: coef = $signed(cfg.rot[row_ff][47:32]);
      endcase
      case (col_ff)
         2'd0:    psel = $signed(item_ff.px);
         2'd1:    psel = $signed(item_ff.py);
         default: psel = $signed(item_ff.pz);
      endcase
   end

   // one coefficient per cycle, row closes with rounding, translation and saturation
   assign prod = coef * psel;
   assign sum  = acc_ff + 50'(prod);
   assign rnd  = sum + 50'sd8192;
   assign shd  = 36'(rnd >>> 14);
   assign tot  = 37'(shd) + 37'($signed(cfg.trans[row_ff]));

   always_comb begin
      if (tot > 37'sd2147483647) begin
         row_res = 32'h7fffffff;
      end else if (tot < -37'sd2147483648) begin
         row_res = 32'h80000000;
      end else begin
         row_res = tot[31:0];
      end
   end

   always_comb begin
      q_item    = item_ff;
      q_item.ok = item_ff.ok && !item_ff.pz[31] && (item_ff.pz != 32'd0)
                  && !item_ff.c2z[31] && (item_ff.c2z != 32'd0);
   end

   assign q_push = (state_ff == hrr_pkg::F_PUSH) && !q_full;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hrr_pkg::F_IDLE: begin
            if (accept) state_in = hrr_pkg::F_MAC;
         end
         hrr_pkg::F_MAC: begin
            if (row_ff == 2'd2 && col_ff == 2'd2) state_in = hrr_pkg::F_PUSH;
         end
         hrr_pkg::F_PUSH: begin
            if (!q_full) state_in = hrr_pkg::F_IDLE;
         end
         default: state_in = hrr_pkg::F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hrr_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.px   <= req_point_x;
         item_ff.py   <= req_point_y;
         item_ff.pz   <= req_point_z;
         item_ff.ok   <= req_point_ok;
         item_ff.ou1  <= req_obs_u1;
         item_ff.ov1  <= req_obs_v1;
         item_ff.ou2  <= req_obs_u2;
         item_ff.ov2  <= req_obs_v2;
         item_ff.last <= req_batch_end;
         row_ff       <= 2'd0;
         col_ff       <= 2'd0;
         acc_ff       <= '0;
      end else if (state_ff == hrr_pkg::F_MAC) begin
         if (col_ff == 2'd2) begin
            case (row_ff)
               2'd0:    item_ff.c2x <= row_res;
               2'd1:    item_ff.c2y <= row_res;
               default: item_ff.c2z <= row_res;
            endcase
            acc_ff <= '0;
            col_ff <= 2'd0;
            row_ff <= row_ff + 2'd1;
         end else begin
            acc_ff <= sum;
            col_ff <= col_ff + 2'd1;
         end
      end
   end

endmodule

[rtl/hrr_queue.sv]
module hrr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hrr_pkg::hrr_item_type item_in,
   output logic                  full,
   input  logic                  pop,
   output hrr_pkg::hrr_item_type item_out,
   output logic                  empty
);

   localparam int PTR_W = $clog2(hrr_pkg::QUEUE_DEPTH);

   hrr_pkg::hrr_item_type slot_ff [hrr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ff, rd_ff;
   logic [PTR_W:0]        cnt_ff;
   logic                  do_push, do_pop;

   assign full     = (cnt_ff == (PTR_W+1)'(hrr_pkg::QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign item_out = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= item_in;
   end

endmodule

[rtl/hrr_div.sv]
module hrr_div (
   input  logic                      clock,
   input  logic                      reset,
   input  hrr_pkg::hrr_div_req_type  req,
   output hrr_pkg::hrr_div_resp_type resp
);

   logic        busy_ff, done_ff;
   logic [6:0]  cnt_ff;
   logic [63:0] q_ff;
   logic [31:0] rem_ff, den_ff;
   logic [32:0] rem_sh;
   logic        ge;

   // restoring division, one quotient bit per cycle
   assign rem_sh = {rem_ff, q_ff[63]};
   assign ge     = (rem_sh >= {1'b0, den_ff});

   assign resp.done = done_ff;
   assign resp.quo  = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 7'd64;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         q_ff   <= req.num;
         den_ff <= req.den;
         rem_ff <= '0;
      end else if (busy_ff) begin
         q_ff   <= {q_ff[62:0], ge};
         rem_ff <= ge ? 32'(rem_sh - {1'b0, den_ff}) : rem_sh[31:0];
      end
   end

endmodule

[rtl/hrr_back.sv]
module hrr_back #(
   parameter int MAX_BATCH = hrr_pkg::MAX_BATCH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  hrr_pkg::hrr_cfg_type      cfg,
   input  hrr_pkg::hrr_item_type     q_item,
   input  logic                      q_empty,
   output logic                      q_pop,
   output hrr_pkg::hrr_div_req_type  div_req,
   input  hrr_pkg::hrr_div_resp_type div_resp,
   output logic                      empty,
   input  logic                      pop,
   output logic [31:0]               rsp_res_u1,
   output logic [31:0]               rsp_res_v1,
   output logic [31:0]               rsp_res_u2,
   output logic [31:0]               rsp_res_v2,
   output logic                      rsp_res_ok,
   output logic                      rsp_batch_done,
   output logic [47:0]               rsp_mean_wrss,
   output logic [16:0]               rsp_valid_count
);

   localparam int CAP = (MAX_BATCH > hrr_pkg::TALLY_LIMIT) ? hrr_pkg::TALLY_LIMIT : MAX_BATCH;
   localparam logic [hrr_pkg::TALLY_W-1:0] TALLY_CAP = hrr_pkg::TALLY_W'(CAP);

   hrr_pkg::hrr_back_state_type state_ff, state_in;
   hrr_pkg::hrr_item_type       it_ff;
   logic [1:0]                  idx_ff;
   logic                        neg_ff;
   logic signed [24:0]          w_ff [4];
   logic [50:0]                 sq_ff;
   logic [63:0]                 sum_ff;
   logic [hrr_pkg::TALLY_W-1:0] tally_ff;
   logic [47:0]                 mean_ff;

   logic                        out_valid_ff;
   logic signed [24:0]          out_w_ff [4];
   logic                        out_ok_ff, out_done_ff;
   logic [47:0]                 out_mean_ff;
   logic [hrr_pkg::TALLY_W-1:0] out_cnt_ff;

   logic               load, out_load, mean_start, out_free;
   logic signed [31:0] c_sel, z_sel, obs_sel;
   logic [23:0]        pp_sel;
   logic [31:0]        mag;
   logic [55:0]        prod_f;
   logic [63:0]        num;
   logic [62:0]        qc;
   logic signed [64:0] qs, pred, rr, ks, nks;
   logic signed [24:0] w_new, w_sel;
   logic signed [49:0] sqp;
   logic [64:0]        sum_add;
   logic [48:0]        mr;

   assign out_free = !out_valid_ff || pop;

   always_comb begin
      case (idx_ff)
         2'd0: begin
            c_sel = $signed(it_ff.px);  obs_sel = $signed(it_ff.ou1); pp_sel = cfg.cx;
         end
         2'd1: begin
            c_sel = $signed(it_ff.py);  obs_sel = $signed(it_ff.ov1); pp_sel = cfg.cy;
         end
         2'd2: begin
            c_sel = $signed(it_ff.c2x); obs_sel = $signed(it_ff.ou2); pp_sel = cfg.cx;
         end
         default: begin
            c_sel = $signed(it_ff.c2y); obs_sel = $signed(it_ff.ov2); pp_sel = cfg.cy;
         end
      endcase
      z_sel = idx_ff[1] ? $signed(it_ff.c2z) : $signed(it_ff.pz);
   end

   // numerator f*|c|*2^8 plus half the depth for rounding
   assign mag    = c_sel[31] ? (~c_sel + 32'd1) : c_sel;
   assign prod_f = mag * cfg.f;
   assign num    = {prod_f, 8'b0} + {33'b0, z_sel[31:1]};

   assign qc   = (div_resp.quo > 64'h4000000000000000) ? 63'h4000000000000000
                                                       : div_resp.quo[62:0];
   assign qs   = neg_ff ? -$signed({2'b0, qc}) : $signed({2'b0, qc});
   assign pred = qs + $signed({33'b0, pp_sel, 8'b0});
   assign rr   = pred - 65'(obs_sel);
   assign ks   = $signed({41'b0, cfg.k, 8'b0});
   assign nks  = -ks;

   always_comb begin
      if (rr > ks) begin
         w_new = ks[24:0];
      end else if (rr < nks) begin
         w_new = nks[24:0];
      end else begin
         w_new = rr[24:0];
      end
   end

   assign w_sel   = w_ff[idx_ff];
   assign sqp     = w_sel * w_sel;
   assign sum_add = {1'b0, sum_ff} + 65'(sq_ff);

   assign mr = {1'b0, div_resp.quo[63:16]} + 49'(div_resp.quo[15]);

   assign mean_start = it_ff.last && (tally_ff != '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hrr_pkg::B_IDLE: begin
            if (!q_empty) state_in = q_item.ok ? hrr_pkg::B_MUL : hrr_pkg::B_ACC;
         end
         hrr_pkg::B_MUL: state_in = hrr_pkg::B_DIV;
         hrr_pkg::B_DIV: begin
            if (div_resp.done) state_in = hrr_pkg::B_RES;
         end
         hrr_pkg::B_RES: state_in = (idx_ff == 2'd3) ? hrr_pkg::B_SQ : hrr_pkg::B_MUL;
         hrr_pkg::B_SQ: begin
            if (idx_ff == 2'd3) state_in = hrr_pkg::B_ACC;
         end
         hrr_pkg::B_ACC: state_in = hrr_pkg::B_MEAN;
         hrr_pkg::B_MEAN: state_in = mean_start ? hrr_pkg::B_MWAIT : hrr_pkg::B_OUT;
         hrr_pkg::B_MWAIT: begin
            if (div_resp.done) state_in = hrr_pkg::B_OUT;
         end
         hrr_pkg::B_OUT: begin
            if (out_free) state_in = hrr_pkg::B_IDLE;
         end
         default: state_in = hrr_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      load          = 1'b0;
      out_load      = 1'b0;
      div_req.start = 1'b0;
      div_req.num   = num;
      div_req.den   = z_sel;
      case (state_ff)
         hrr_pkg::B_IDLE: load = !q_empty;
         hrr_pkg::B_MUL:  div_req.start = 1'b1;
         hrr_pkg::B_MEAN: begin
            div_req.start = mean_start;
            div_req.num   = sum_ff;
            div_req.den   = 32'(tally_ff);
         end
         hrr_pkg::B_OUT:  out_load = out_free;
         default: begin
         end
      endcase
   end

   assign q_pop = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hrr_pkg::B_IDLE;
         out_valid_ff <= 1'b0;
         sum_ff       <= '0;
         tally_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
         if (state_ff == hrr_pkg::B_ACC && it_ff.ok) begin
            sum_ff <= sum_add[64] ? '1 : sum_add[63:0];
            if (tally_ff < TALLY_CAP) tally_ff <= tally_ff + 1'b1;
         end else if (out_load && it_ff.last) begin
            sum_ff   <= '0;
            tally_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         hrr_pkg::B_IDLE: begin
            if (load) begin
               it_ff  <= q_item;
               idx_ff <= 2'd0;
               sq_ff  <= '0;
               for (int i = 0; i < 4; i++) w_ff[i] <= '0;
            end
         end
         hrr_pkg::B_MUL: neg_ff <= c_sel[31];
         hrr_pkg::B_RES: begin
            w_ff[idx_ff] <= w_new;
            idx_ff       <= idx_ff + 2'd1;
         end
         hrr_pkg::B_SQ: begin
            sq_ff  <= sq_ff + {1'b0, sqp};
            idx_ff <= idx_ff + 2'd1;
         end
         hrr_pkg::B_MEAN: mean_ff <= '0;
         hrr_pkg::B_MWAIT: begin
            if (div_resp.done) mean_ff <= mr[48] ? '1 : mr[47:0];
         end
         hrr_pkg::B_OUT: begin
            if (out_load) begin
               for (int i = 0; i < 4; i++) out_w_ff[i] <= w_ff[i];
               out_ok_ff   <= it_ff.ok;
               out_done_ff <= it_ff.last;
               out_mean_ff <= it_ff.last ? mean_ff : '0;
               out_cnt_ff  <= it_ff.last ? tally_ff : '0;
            end
         end
         default: begin
         end
      endcase
   end

   assign empty           = !out_valid_ff;
   assign rsp_res_u1      = 32'(out_w_ff[0]);
   assign rsp_res_v1      = 32'(out_w_ff[1]);
   assign rsp_res_u2      = 32'(out_w_ff[2]);
   assign rsp_res_v2      = 32'(out_w_ff[3]);
   assign rsp_res_ok      = out_ok_ff;
   assign rsp_batch_done  = out_done_ff;
   assign rsp_mean_wrss   = out_mean_ff;
   assign rsp_valid_count = out_cnt_ff;

   a_tally_cap: assert property (@(posedge clock) disable iff (reset)
      tally_ff <= TALLY_CAP)
      else $error("tally above cap");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ok_ff |-> (out_w_ff[0] == 0) && (out_w_ff[1] == 0)
                                     && (out_w_ff[2] == 0) && (out_w_ff[3] == 0))
      else $error("invalid point with nonzero residual");

   a_mid_batch: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_done_ff |-> (out_mean_ff == '0) && (out_cnt_ff == '0))
      else $error("batch totals outside batch end");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !out_valid_ff || pop)
      else $error("result register overwritten");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> !div_resp.done)
      else $error("divider done right after start");

endmodule

[rtl/huber_reprojection_residuals.sv]
// channel   | handshake            | payload
// request   | push / full          | req_point_x..z, req_point_ok, req_obs_*, req_batch_end
// result    | pop / empty          | rsp_res_*, rsp_res_ok, rsp_batch_done, rsp_mean_wrss,
//           |                      | rsp_valid_count
// csr       | psel penable pwrite  | paddr (8*index), pwdata, prdata, pready
//
// a request is taken once the last is pushed (9 multiply-accumulate steps for camera 2 + push)
// the back handles one request at a time: for a valid one, four residuals, each with a wait on
// the shared 64-step divider, plus the load, squares, sum and output
// an invalid request skips the residuals; a batch end with valid points adds a divide for the mean
// reset is synchronous; it restores the csr defaults and clears the batch sums
// a two-entry queue between front and back, and the result register, let either side stall

module huber_reprojection_residuals #(
   parameter int MAX_BATCH = hrr_pkg::MAX_BATCH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic [31:0]                req_point_x,
   input  logic [31:0]                req_point_y,
   input  logic [31:0]                req_point_z,
   input  logic                       req_point_ok,
   input  logic [31:0]                req_obs_u1,
   input  logic [31:0]                req_obs_v1,
   input  logic [31:0]                req_obs_u2,
   input  logic [31:0]                req_obs_v2,
   input  logic                       req_batch_end,
   output logic                       empty,
   input  logic                       pop,
   output logic [31:0]                rsp_res_u1,
   output logic [31:0]                rsp_res_v1,
   output logic [31:0]                rsp_res_u2,
   output logic [31:0]                rsp_res_v2,
   output logic                       rsp_res_ok,
   output logic                       rsp_batch_done,
   output logic [47:0]                rsp_mean_wrss,
   output logic [16:0]                rsp_valid_count,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [hrr_pkg::ADDR_W-1:0] paddr,
   input  logic [63:0]                pwdata,
   output logic [63:0]                prdata,
   output logic                       pready
);

   logic [2:0][47:0] rot_ff;
   logic [2:0][31:0] trans_ff;
   logic [47:0]      pp_ff;
   logic [39:0]      fk_ff;
   logic [2:0]       reg_idx;
   logic             wr_en;

   hrr_pkg::hrr_cfg_type      cfg;
   hrr_pkg::hrr_item_type     f_item, q_item;
   logic                      f_push, q_full, q_empty, q_pop;
   hrr_pkg::hrr_div_req_type  div_req;
   hrr_pkg::hrr_div_resp_type div_resp;

   assign pready  = 1'b1;
   assign reg_idx = paddr[5:3];
   assign wr_en   = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= 48'd16384;
         rot_ff[1] <= 48'd1073741824;
         rot_ff[2] <= 48'd70368744177664;
         trans_ff  <= '0;
         pp_ff     <= '0;
         fk_ff     <= 40'd4294967552;
      end else if (wr_en) begin
         case (reg_idx)
            hrr_pkg::REG_ROT0:  rot_ff[0]   <= pwdata[47:0];
            hrr_pkg::REG_ROT1:  rot_ff[1]   <= pwdata[47:0];
            hrr_pkg::REG_ROT2:  rot_ff[2]   <= pwdata[47:0];
            hrr_pkg::REG_TX:    trans_ff[0] <= pwdata[31:0];
            hrr_pkg::REG_TY:    trans_ff[1] <= pwdata[31:0];
            hrr_pkg::REG_TZ:    trans_ff[2] <= pwdata[31:0];
            hrr_pkg::REG_PP:    pp_ff       <= pwdata[47:0];
            hrr_pkg::REG_FOCAL: fk_ff       <= pwdata[39:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         hrr_pkg::REG_ROT0:  prdata = {16'b0, rot_ff[0]};
         hrr_pkg::REG_ROT1:  prdata = {16'b0, rot_ff[1]};
         hrr_pkg::REG_ROT2:  prdata = {16'b0, rot_ff[2]};
         hrr_pkg::REG_TX:    prdata = {32'b0, trans_ff[0]};
         hrr_pkg::REG_TY:    prdata = {32'b0, trans_ff[1]};
         hrr_pkg::REG_TZ:    prdata = {32'b0, trans_ff[2]};
         hrr_pkg::REG_PP:    prdata = {16'b0, pp_ff};
         hrr_pkg::REG_FOCAL: prdata = {24'b0, fk_ff};
         default:            prdata = '0;
      endcase
   end

   always_comb begin
      cfg.rot   = rot_ff;
      cfg.trans = trans_ff;
      cfg.cx    = pp_ff[23:0];
      cfg.cy    = pp_ff[47:24];
      cfg.f     = fk_ff[23:0];
      cfg.k     = fk_ff[39:24];
   end

   hrr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .push          (push),
      .full          (full),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_point_z   (req_point_z),
      .req_point_ok  (req_point_ok),
      .req_obs_u1    (req_obs_u1),
      .req_obs_v1    (req_obs_v1),
      .req_obs_u2    (req_obs_u2),
      .req_obs_v2    (req_obs_v2),
      .req_batch_end (req_batch_end),
      .q_push        (f_push),
      .q_item        (f_item),
      .q_full        (q_full)
   );

   hrr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_push),
      .item_in  (f_item),
      .full     (q_full),
      .pop      (q_pop),
      .item_out (q_item),
      .empty    (q_empty)
   );

   hrr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .resp  (div_resp)
   );

   hrr_back #(
      .MAX_BATCH (MAX_BATCH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .q_item          (q_item),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .div_req         (div_req),
      .div_resp        (div_resp),
      .empty           (empty),
      .pop             (pop),
      .rsp_res_u1      (rsp_res_u1),
      .rsp_res_v1      (rsp_res_v1),
      .rsp_res_u2      (rsp_res_u2),
      .rsp_res_v2      (rsp_res_v2),
      .rsp_res_ok      (rsp_res_ok),
      .rsp_batch_done  (rsp_batch_done),
      .rsp_mean_wrss   (rsp_mean_wrss),
      .rsp_valid_count (rsp_valid_count)
   );

endmodule
